// ----- rtl/pes_stream_pts_cutter_macros.svh -----
// Assertion macros used by the checker of the PES stream cutter.
`ifndef PES_STREAM_PTS_CUTTER_MACROS_SVH
`define PES_STREAM_PTS_CUTTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high.
`define PSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/psc_pkg.sv -----
// Types and constants shared by the PES stream cutter modules.
package psc_pkg;

   localparam int HDR_BYTES = 19;
   localparam int HDR_CNT_W = $clog2(HDR_BYTES + 1);
   localparam int STAMP_W = 33;
   localparam int FRAME_TICKS_INT = 3600;
   localparam logic [STAMP_W:0] FRAME_TICKS = (STAMP_W + 1)'(FRAME_TICKS_INT);

   // The quotient by 3600 is the quotient by 225 of the stamp shifted right by four,
   // taken by a reciprocal multiplication that is exact for every 29-bit operand.
   localparam int FRAME_SUB_SHIFT = 4;
   localparam int RECIP_W = 30;
   localparam int RECIP_SHIFT = 37;
   localparam logic [RECIP_W-1:0] FRAME_RECIP = 30'd610839794;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-4:0] REG_STOP_PTS = '0;

   localparam logic [7:0] START_PREFIX = 8'h01;
   localparam logic [3:0] VIDEO_ID_NIB = 4'hE;
   localparam logic [2:0] AUDIO_ID_TOP = 3'h6;
   localparam logic [7:0] PTS_HI_MASK = 8'h0F;
   localparam logic [7:0] EXT_HDR_LIMIT = 8'd5;
   localparam logic [HDR_CNT_W-1:0] WINDOW_HDR_LEN = HDR_CNT_W'(4);
   localparam logic [HDR_CNT_W-1:0] VIDEO_SHORT = HDR_CNT_W'(14);
   localparam logic [HDR_CNT_W-1:0] VIDEO_LONG = HDR_CNT_W'(HDR_BYTES);
   localparam logic [HDR_CNT_W-1:0] AUDIO_LEN_END = HDR_CNT_W'(6);
   localparam logic [HDR_CNT_W-1:0] AUDIO_HDR_END = HDR_CNT_W'(14);

   // One job per input byte that causes results. A count of zero means a
   // single closing beat that carries no byte.
   typedef struct packed {
      logic [HDR_BYTES-1:0][7:0] bytes;
      logic [HDR_CNT_W-1:0]      count;
      logic                      close;
   } psc_job_type;

endpackage

// ----- rtl/psc_if.sv -----
// Valid/ready channel interfaces for the input bytes and the result beats.
interface psc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface psc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       stream_closed;
   logic       last_of_run;

   modport source (output valid, output out_byte, output byte_valid,
                   output stream_closed, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input stream_closed, input last_of_run, output ready);
endinterface

// ----- rtl/pes_stream_pts_cutter.sv -----
// Top level of the PES stream cutter: register port, front end, job queue, back end.
//
// The block takes one stream byte per beat and accepts a new byte in every cycle
// while its job queue has room; the first result beat of a byte passes the queue,
// the current-job register and the output register. A byte causes at most one job,
// and the back end sends one beat per cycle while the output is taken, so a header
// burst of up to 19 beats holds the back end while the front end keeps taking bytes
// until the QUEUE_DEPTH jobs are full. After each write of stop_pts the input is
// held off while the stop value is rounded down to a multiple of 3600 by a
// reciprocal multiplication. stop_pts sits at byte address 0 of the register port.
module pes_stream_pts_cutter import psc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   psc_req_if.sink               req_chan,
   psc_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic               cfg_busy;
   logic [STAMP_W-1:0] stop_pts;
   logic               accept;
   logic               push;
   psc_job_type        push_job;
   logic               space;
   logic               head_valid;
   psc_job_type        head_job;
   logic               pop;

   assign req_chan.ready = space && !cfg_busy;
   assign accept = req_chan.valid && req_chan.ready;

   psc_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .stop_pts (stop_pts),
      .busy     (cfg_busy)
   );

   psc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .stop_pts     (stop_pts),
      .push         (push),
      .job          (push_job)
   );

   psc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .space      (space),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   psc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

// ----- rtl/psc_cfg.sv -----
// Register port and rounding of the stop stamp down to a frame multiple.
module psc_cfg import psc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [STAMP_W-1:0]    stop_pts,
   output logic                  busy
);

   localparam int PROD_W = STAMP_W - FRAME_SUB_SHIFT + RECIP_W;
   localparam int QUO_W = PROD_W - RECIP_SHIFT;

   logic [STAMP_W-1:0] stop_ff, stop_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               busy_ff, busy_in;

   logic               wr;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1:3] == REG_STOP_PTS);
      prod = PROD_W'(pwdata[STAMP_W-1:FRAME_SUB_SHIFT]) * PROD_W'(FRAME_RECIP);

      stop_in = stop_ff;
      quo_in = quo_ff;
      busy_in = 1'b0;
      if (wr) begin
         quo_in = prod[PROD_W-1:RECIP_SHIFT];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         stop_in = STAMP_W'(quo_ff) * FRAME_TICKS[STAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         stop_ff <= stop_in;
         busy_ff <= busy_in;
      end
      quo_ff <= quo_in;
   end

   assign prdata = CSR_DATA_W'(stop_ff);
   assign pready = 1'b1;
   assign stop_pts = stop_ff;
   assign busy = busy_ff;

endmodule

// ----- rtl/psc_front.sv -----
// Front end: start-code window, header collection, stamp tracking and job issue.
module psc_front import psc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               end_of_input,
   input  logic [STAMP_W-1:0] stop_pts,
   output logic               push,
   output psc_job_type        job
);

   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_VIDEO  = 4'b0010,
      PH_ALEN   = 4'b0100,
      PH_AREST  = 4'b1000
   } psc_phase_type;

   psc_phase_type             phase_ff, phase_in;
   logic [1:0]                fill_ff, fill_in;
   logic [2:0][7:0]           win_ff, win_in;
   logic [HDR_BYTES-1:0][7:0] hs_ff, hs_in;
   logic [HDR_CNT_W-1:0]      hc_ff, hc_in;
   logic [15:0]               alen_ff, alen_in;
   logic [STAMP_W-1:0]        stamp_ff, stamp_in;
   logic                      closed_ff, closed_in;

   logic [HDR_BYTES-1:0][7:0] hs_new;
   logic [HDR_CNT_W-1:0]      hc_inc;
   logic [HDR_CNT_W-1:0]      video_len;
   logic                      is_video, is_audio, start_hit;
   logic                      stop_on;
   logic [STAMP_W:0]          next_stamp, pts_ahead;
   logic [STAMP_W-1:0]        pts;
   logic [7:0]                pts_hi;
   logic [15:0]               len;

   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         hs_new[i] = (hc_ff == HDR_CNT_W'(i)) ? in_byte : hs_ff[i];
      end
   end

   always_comb begin
      hc_inc = hc_ff + 1'b1;
      video_len = (hs_ff[8] > EXT_HDR_LIMIT) ? VIDEO_LONG : VIDEO_SHORT;
      is_video = (in_byte[7:4] == VIDEO_ID_NIB);
      is_audio = (in_byte[7:5] == AUDIO_ID_TOP);
      start_hit = (win_ff[0] == 8'h00) && (win_ff[1] == 8'h00) &&
                  (win_ff[2] == START_PREFIX) && (is_video || is_audio);
      stop_on = {1'b0, stop_pts} > FRAME_TICKS;
      next_stamp = {1'b0, stamp_ff} + FRAME_TICKS;
      pts_hi = hs_ff[9] & PTS_HI_MASK;
      pts = {pts_hi[3:1], hs_ff[10], hs_ff[11][7:1], hs_ff[12], in_byte[7:1]};
      pts_ahead = {1'b0, pts} + FRAME_TICKS;
      len = {hs_ff[4], in_byte};

      phase_in = phase_ff;
      fill_in = fill_ff;
      win_in = win_ff;
      hs_in = hs_ff;
      hc_in = hc_ff;
      alen_in = alen_ff;
      stamp_in = stamp_ff;
      closed_in = closed_ff;
      push = 1'b0;
      job.bytes = hs_new;
      job.count = '0;
      job.close = 1'b0;

      if (accept && !closed_ff) begin
         if (end_of_input) begin
            closed_in = 1'b1;
            push = 1'b1;
            job.close = 1'b1;
            if (phase_ff == PH_SEARCH) begin
               job.bytes = '0;
               job.bytes[2:0] = win_ff;
               job.count = HDR_CNT_W'(fill_ff);
            end else begin
               job.bytes = hs_ff;
               job.count = hc_ff;
            end
         end else begin
            case (phase_ff)
               PH_SEARCH: begin
                  if (fill_ff != 2'd3) begin
                     win_in[fill_ff] = in_byte;
                     fill_in = fill_ff + 1'b1;
                  end else if (start_hit) begin
                     hs_in[2:0] = win_ff;
                     hs_in[3] = in_byte;
                     hc_in = WINDOW_HDR_LEN;
                     phase_in = is_video ? PH_VIDEO : PH_ALEN;
                     fill_in = '0;
                  end else begin
                     push = 1'b1;
                     job.bytes = '0;
                     job.bytes[0] = win_ff[0];
                     job.count = HDR_CNT_W'(1);
                     win_in[0] = win_ff[1];
                     win_in[1] = win_ff[2];
                     win_in[2] = in_byte;
                  end
               end
               PH_VIDEO: begin
                  hs_in = hs_new;
                  hc_in = hc_inc;
                  if (hc_inc == video_len) begin
                     push = 1'b1;
                     if (stop_on && (next_stamp >= {1'b0, stop_pts})) begin
                        job.close = 1'b1;
                        closed_in = 1'b1;
                     end else begin
                        stamp_in = next_stamp[STAMP_W-1:0];
                        job.count = video_len;
                        hc_in = '0;
                        phase_in = PH_SEARCH;
                     end
                  end
               end
               PH_ALEN: begin
                  hs_in = hs_new;
                  hc_in = hc_inc;
                  if (hc_inc == AUDIO_LEN_END) begin
                     if ((alen_ff != 16'd0) && (alen_ff != len)) begin
                        push = 1'b1;
                        job.count = AUDIO_LEN_END;
                        hc_in = '0;
                        phase_in = PH_SEARCH;
                     end else begin
                        alen_in = len;
                        phase_in = PH_AREST;
                     end
                  end
               end
               PH_AREST: begin
                  hs_in = hs_new;
                  hc_in = hc_inc;
                  if (hc_inc == AUDIO_HDR_END) begin
                     push = 1'b1;
                     if (stop_on && (pts_ahead >= {1'b0, stop_pts})) begin
                        job.close = 1'b1;
                        closed_in = 1'b1;
                     end else begin
                        stamp_in = pts;
                        job.count = AUDIO_HDR_END;
                        hc_in = '0;
                        phase_in = PH_SEARCH;
                     end
                  end
               end
               default: begin
                  phase_in = PH_SEARCH;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         fill_ff <= '0;
         hc_ff <= '0;
         alen_ff <= '0;
         stamp_ff <= '0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         hc_ff <= hc_in;
         alen_ff <= alen_in;
         stamp_ff <= stamp_in;
         closed_ff <= closed_in;
      end
      win_ff <= win_in;
      hs_ff <= hs_in;
   end

endmodule

// ----- rtl/psc_queue.sv -----
// Job queue between the front end and the beat generator.
module psc_queue import psc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  psc_job_type push_job,
   output logic        space,
   output logic        head_valid,
   output psc_job_type head_job,
   input  logic        pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   psc_job_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign space = (cnt_ff < CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/psc_back.sv -----
// Back end: turns jobs into result beats through a registered output stage.
module psc_back import psc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  psc_job_type  job,
   output logic         pop,
   psc_rsp_if.source    rsp
);

   logic [HDR_BYTES-1:0][7:0] cur_bytes_ff, cur_bytes_in;
   logic [HDR_CNT_W-1:0]      cur_left_ff, cur_left_in;
   logic                      cur_blank_ff, cur_blank_in;
   logic                      cur_close_ff, cur_close_in;
   logic                      cur_valid_ff, cur_valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      byte_valid_ff, byte_valid_in;
   logic                      closed_ff, closed_in;
   logic                      last_ff, last_in;

   logic                      out_free, emit, last_beat, load;

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      emit = cur_valid_ff && out_free;
      last_beat = (cur_left_ff == HDR_CNT_W'(1));
      load = job_valid && (!cur_valid_ff || (emit && last_beat));
      pop = load;

      cur_bytes_in = cur_bytes_ff;
      cur_left_in = cur_left_ff;
      cur_blank_in = cur_blank_ff;
      cur_close_in = cur_close_ff;
      cur_valid_in = cur_valid_ff;
      if (load) begin
         cur_bytes_in = job.bytes;
         cur_blank_in = (job.count == '0);
         cur_left_in = (job.count == '0) ? HDR_CNT_W'(1) : job.count;
         cur_close_in = job.close;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         cur_bytes_in = {8'h00, cur_bytes_ff[HDR_BYTES-1:1]};
         cur_left_in = cur_left_ff - 1'b1;
         if (last_beat) begin
            cur_valid_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      out_byte_in = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      closed_in = closed_ff;
      last_in = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (cur_blank_ff) begin
            out_byte_in = 8'h00;
            byte_valid_in = 1'b0;
            closed_in = 1'b1;
            last_in = 1'b1;
         end else begin
            out_byte_in = cur_bytes_ff[0];
            byte_valid_in = 1'b1;
            closed_in = cur_close_ff && last_beat;
            last_in = last_beat;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_bytes_ff <= cur_bytes_in;
      cur_left_ff <= cur_left_in;
      cur_blank_ff <= cur_blank_in;
      cur_close_ff <= cur_close_in;
      out_byte_ff <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      closed_ff <= closed_in;
      last_ff <= last_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.stream_closed = closed_ff;
   assign rsp.last_of_run = last_ff;

endmodule

// ----- rtl/psc_checker.sv -----
// Port-level checker for the PES stream cutter and its bind to the top level.
`include "pes_stream_pts_cutter_macros.svh"

module psc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       byte_valid,
   input logic       stream_closed,
   input logic       last_of_run
);

   logic closed_seen_ff, closed_seen_in;
   logic blank_ok;

   assign closed_seen_in = closed_seen_ff || (rsp_valid && rsp_ready && stream_closed);
   assign blank_ok = (out_byte == 8'h00) && stream_closed && last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_seen_ff <= 1'b0;
      end else begin
         closed_seen_ff <= closed_seen_in;
      end
   end

   `PSC_ASSERT_NXT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PSC_ASSERT_IMP(a_blank_beat, clock, reset, rsp_valid && !byte_valid, blank_ok)
   `PSC_ASSERT_IMP(a_close_ends_run, clock, reset, rsp_valid && stream_closed, last_of_run)
   `PSC_ASSERT_IMP(a_silent_after_close, clock, reset, closed_seen_ff, !rsp_valid)

endmodule

bind pes_stream_pts_cutter psc_checker u_psc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .out_byte      (rsp_chan.out_byte),
   .byte_valid    (rsp_chan.byte_valid),
   .stream_closed (rsp_chan.stream_closed),
   .last_of_run   (rsp_chan.last_of_run)
);

// ----- dv/pes_stream_pts_cutter_test.sv -----
// Self-checking testbench for the PES stream cutter: directed, random and closing cases.
module pes_stream_pts_cutter_test;
   import psc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD = 160;
   localparam int EXT_FLAG_IDX = 8;
   localparam int PTS_AT = 9;
   localparam int DIRECTED_COUNT = 32;
   localparam logic [CSR_ADDR_W-1:0] STOP_PTS_ADDR = {REG_STOP_PTS, 3'b000};
   localparam logic [32:0] STAMP_MAX = '1;

   typedef enum logic [3:0] {
      SCAN_WINDOW  = 4'b0001,
      VIDEO_HEADER = 4'b0010,
      AUDIO_LENGTH = 4'b0100,
      AUDIO_REST   = 4'b1000
   } parse_type;
   typedef enum logic [1:0] {
      CUT_BY_VIDEO, CUT_BY_AUDIO, END_IN_WINDOW, END_IN_HEADER
   } ending_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       stream_closed;
      logic       last_of_run;
   } out_beat_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
      logic       typed;
      logic [7:0] typed_byte;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h7F, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b1, 8'hFF},
      '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'h7F},
      '{8'h01, 1'b0, 1'b1, 8'h80}, '{8'hE0, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00},
      '{8'h05, 1'b0, 1'b0, 8'h00}, '{8'hAA, 1'b0, 1'b0, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h3C, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h01, 1'b0, 1'b0, 8'h00}, '{8'hC0, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h7F, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   psc_req_if req_chan ();
   psc_rsp_if rsp_chan ();

   pes_stream_pts_cutter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic [7:0]  win_bytes [4];
   int unsigned win_fill;
   logic [7:0]  hdr_bytes [HDR_BYTES];
   int unsigned hdr_count;
   parse_type   phase;
   logic [15:0] first_audio_len;
   logic [32:0] stamp;
   logic [32:0] stop_stamp;
   bit          stream_done;

   out_beat_type fresh_beats [$];
   out_beat_type beats_due [$];
   stim_row_type plan [$];

   int          errors = 0;
   bit          calm = 1'b0;
   int unsigned send_quiet = 0;
   int unsigned items_taken = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void cutter_reset();
      foreach (win_bytes[k]) win_bytes[k] = 8'h00;
      foreach (hdr_bytes[k]) hdr_bytes[k] = 8'h00;
      win_fill = 0;
      hdr_count = 0;
      phase = SCAN_WINDOW;
      first_audio_len = '0;
      stamp = '0;
      stop_stamp = '0;
      stream_done = 1'b0;
   endfunction

   function automatic void set_stop(logic [32:0] value);
      logic [63:0] v;
      v = 64'(value);
      stop_stamp = 33'(v - v % FRAME_TICKS_INT);
   endfunction

   function automatic void push_beat(logic [7:0] b, logic v, logic c);
      out_beat_type r;
      r.out_byte = v ? b : 8'h00;
      r.byte_valid = v;
      r.stream_closed = c;
      r.last_of_run = 1'b0;
      fresh_beats.push_back(r);
   endfunction

   function automatic void replay_header(int unsigned count, bit close_last);
      for (int unsigned k = 0; k < count && k < HDR_BYTES; k++)
         push_beat(hdr_bytes[k], 1'b1, close_last && (k + 1 == count));
   endfunction

   function automatic void close_stream();
      stream_done = 1'b1;
      push_beat(8'h00, 1'b0, 1'b1);
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      win_bytes[win_fill] = b;
      win_fill++;
      if (win_fill < 4) return;
      if (win_bytes[0] == 8'h00 && win_bytes[1] == 8'h00 && win_bytes[2] == START_PREFIX &&
          (win_bytes[3][7:4] == VIDEO_ID_NIB || win_bytes[3][7:5] == AUDIO_ID_TOP)) begin
         for (int k = 0; k < 4; k++) hdr_bytes[k] = win_bytes[k];
         hdr_count = WINDOW_HDR_LEN;
         phase = (win_bytes[3][7:4] == VIDEO_ID_NIB) ? VIDEO_HEADER : AUDIO_LENGTH;
         win_fill = 0;
         return;
      end
      push_beat(win_bytes[0], 1'b1, 1'b0);
      win_bytes[0] = win_bytes[1];
      win_bytes[1] = win_bytes[2];
      win_bytes[2] = win_bytes[3];
      win_fill = 3;
   endfunction

   function automatic void header_byte(logic [7:0] b);
      int unsigned target;
      logic [33:0] next_stamp;
      logic [15:0] len;
      logic [32:0] pts;
      if (hdr_count < HDR_BYTES) hdr_bytes[hdr_count] = b;
      hdr_count++;
      case (phase)
         VIDEO_HEADER: begin
            if (hdr_count < EXT_FLAG_IDX + 1) return;
            target = (hdr_bytes[EXT_FLAG_IDX] > EXT_HDR_LIMIT) ? VIDEO_LONG : VIDEO_SHORT;
            if (hdr_count < target) return;
            next_stamp = {1'b0, stamp} + FRAME_TICKS_INT;
            if (next_stamp >= {1'b0, stop_stamp} && stop_stamp > FRAME_TICKS_INT) begin
               close_stream();
               return;
            end
            stamp = next_stamp[32:0];
            replay_header(target, 1'b0);
            hdr_count = 0;
            phase = SCAN_WINDOW;
         end
         AUDIO_LENGTH: begin
            if (hdr_count < AUDIO_LEN_END) return;
            len = {hdr_bytes[4], hdr_bytes[5]};
            if (first_audio_len != 0 && first_audio_len != len) begin
               replay_header(AUDIO_LEN_END, 1'b0);
               hdr_count = 0;
               phase = SCAN_WINDOW;
               return;
            end
            first_audio_len = len;
            phase = AUDIO_REST;
         end
         default: begin
            if (hdr_count < AUDIO_HDR_END) return;
            pts = {hdr_bytes[PTS_AT][3:1], hdr_bytes[PTS_AT+1], hdr_bytes[PTS_AT+2][7:1],
                   hdr_bytes[PTS_AT+3], hdr_bytes[PTS_AT+4][7:1]};
            if (stop_stamp > FRAME_TICKS_INT && pts >= stop_stamp - FRAME_TICKS_INT) begin
               close_stream();
               return;
            end
            stamp = pts;
            replay_header(AUDIO_HDR_END, 1'b0);
            hdr_count = 0;
            phase = SCAN_WINDOW;
         end
      endcase
   endfunction

   function automatic void predict_pes_byte(logic [7:0] b, logic eoi);
      int unsigned c;
      fresh_beats.delete();
      if (stream_done) return;
      if (eoi) begin
         if (phase == SCAN_WINDOW) begin
            if (win_fill == 0) close_stream();
            else begin
               for (int unsigned k = 0; k < win_fill; k++)
                  push_beat(win_bytes[k], 1'b1, k + 1 == win_fill);
               stream_done = 1'b1;
            end
         end else begin
            c = (hdr_count > HDR_BYTES) ? HDR_BYTES : hdr_count;
            if (c == 0) close_stream();
            else begin
               replay_header(c, 1'b1);
               stream_done = 1'b1;
            end
         end
      end else if (phase == SCAN_WINDOW) begin
         scan_byte(b);
      end else begin
         header_byte(b);
      end
      if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void plan_byte(logic [7:0] b, logic eoi = 1'b0);
      stim_row_type row;
      row.in_byte = b;
      row.end_of_input = eoi;
      row.typed = 1'b0;
      row.typed_byte = 8'h00;
      plan.push_back(row);
   endfunction

   function automatic void plan_start(logic [7:0] id);
      plan_byte(8'h00);
      plan_byte(8'h00);
      plan_byte(START_PREFIX);
      plan_byte(id);
   endfunction

   function automatic void plan_video(bit long_hdr);
      int unsigned total;
      plan_start({VIDEO_ID_NIB, 4'($urandom)});
      total = long_hdr ? VIDEO_LONG : VIDEO_SHORT;
      for (int unsigned k = WINDOW_HDR_LEN; k < total; k++) begin
         if (k == EXT_FLAG_IDX)
            plan_byte(long_hdr ? 8'($urandom_range(EXT_HDR_LIMIT + 1, 255))
                               : 8'($urandom_range(0, EXT_HDR_LIMIT)));
         else
            plan_byte(8'($urandom));
      end
   endfunction

   function automatic void plan_audio(logic [32:0] pts, bit bad_len);
      logic [15:0] len;
      len = 16'($urandom);
      if (first_audio_len != 0)
         len = bad_len ? (first_audio_len ^ 16'($urandom_range(1, 65535))) : first_audio_len;
      plan_start({AUDIO_ID_TOP, 5'($urandom)});
      plan_byte(len[15:8]);
      plan_byte(len[7:0]);
      for (int k = AUDIO_LEN_END; k < PTS_AT; k++) plan_byte(8'($urandom));
      plan_byte({4'($urandom), pts[32:30], 1'($urandom)});
      plan_byte(pts[29:22]);
      plan_byte({pts[21:15], 1'($urandom)});
      plan_byte(pts[14:7]);
      plan_byte({pts[6:0], 1'($urandom)});
   endfunction

   function automatic void plan_noise(int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(0, 7) == 0)
            plan_start($urandom_range(0, 1) ? 8'($urandom_range(0, 8'hBF))
                                            : 8'($urandom_range(8'hF0, 8'hFF)));
         else
            plan_byte(8'($urandom));
      end
   endfunction

   function automatic logic [32:0] random_pts(logic [32:0] cap);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return 33'(r % (64'(cap) + 1));
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic offer_byte(stim_row_type row);
      int unsigned gap;
      out_beat_type r;
      gap = 0;
      if (!calm) begin
         if (send_quiet > 0) send_quiet--;
         else if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) send_quiet = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= row.in_byte;
      req_chan.end_of_input <= row.end_of_input;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      predict_pes_byte(row.in_byte, row.end_of_input);
      if (row.typed) begin
         r.out_byte = row.typed_byte;
         r.byte_valid = 1'b1;
         r.stream_closed = 1'b0;
         r.last_of_run = 1'b1;
         beats_due.push_back(r);
      end else begin
         foreach (fresh_beats[k]) beats_due.push_back(fresh_beats[k]);
      end
      items_taken++;
   endtask

   task automatic send_plan();
      while (plan.size() != 0 && !stream_done) offer_byte(plan.pop_front());
      plan.delete();
   endtask

   task automatic run_random(int unsigned budget, logic [32:0] pts_cap);
      int unsigned first;
      int unsigned pick;
      first = items_taken;
      while (items_taken - first < budget && !stream_done) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) plan_video($urandom_range(0, 2) == 0);
         else if (pick < 7) plan_audio(random_pts(pts_cap), $urandom_range(0, 5) == 0);
         else plan_noise($urandom_range(1, 6));
         send_plan();
      end
   endtask

   task automatic wait_for_idle();
      int unsigned n;
      req_chan.valid <= 1'b0;
      n = 0;
      while (beats_due.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stop_pts(logic [32:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= STOP_PTS_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      set_stop(value);
   endtask

   initial begin : result_sink
      int unsigned stall;
      int unsigned quiet_left;
      int unsigned taken_beats;
      bit long_hold_done;
      out_beat_type want;
      stall = 0;
      quiet_left = 0;
      taken_beats = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            taken_beats++;
            if (beats_due.size() == 0) begin
               errors++;
               $display("%0t: beat with nothing awaited, actual %h/%b/%b/%b", $time,
                        rsp_chan.out_byte, rsp_chan.byte_valid, rsp_chan.stream_closed,
                        rsp_chan.last_of_run);
            end else begin
               want = beats_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_chan.out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_chan.byte_valid));
               check_field("stream_closed", 8'(want.stream_closed), 8'(rsp_chan.stream_closed));
               check_field("last_of_run", 8'(want.last_of_run), 8'(rsp_chan.last_of_run));
            end
         end
         if (!long_hold_done && taken_beats >= 30) begin
            long_hold_done = 1'b1;
            stall = LONG_HOLD;
         end else if (stall == 0 && !calm) begin
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 5) == 0) begin
               stall = $urandom_range(1, 12);
               if ($urandom_range(0, 2) == 0) quiet_left = $urandom_range(20, 80);
            end
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int unsigned keep;
      int unsigned tries;
      logic [32:0] goal;
      ending_type ending;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.end_of_input <= 1'b0;
      cutter_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Cutting is off; the audio header leaves the stamp at its maximum so that the
      // next video frame wraps it.
      write_stop_pts('0);
      for (int k = 0; k < DIRECTED_COUNT; k++) offer_byte(DIRECTED_ROWS[k]);
      run_random(25, STAMP_MAX);

      wait_for_idle();
      write_stop_pts(33'(FRAME_TICKS_INT + $urandom_range(0, FRAME_TICKS_INT - 1)));
      run_random(20, STAMP_MAX);
      plan_audio('0, 1'b0);
      send_plan();

      wait_for_idle();
      write_stop_pts(STAMP_MAX);
      run_random(20, 33'h3FFF_FFFF);

      wait_for_idle();
      calm = 1'b1;
      ending = ending_type'($urandom_range(0, 3));
      case (ending)
         CUT_BY_VIDEO: begin
            goal = 33'((64'(stamp) / FRAME_TICKS_INT + $urandom_range(2, 5)) * FRAME_TICKS_INT);
            write_stop_pts(goal);
            tries = 0;
            while (!stream_done && tries < 50) begin
               plan_video($urandom_range(0, 1));
               send_plan();
               tries++;
            end
         end
         CUT_BY_AUDIO: begin
            goal = 33'(FRAME_TICKS_INT * $urandom_range(2, 100000));
            write_stop_pts(goal);
            plan_audio(goal - FRAME_TICKS_INT + $urandom_range(0, 2 * FRAME_TICKS_INT), 1'b0);
            send_plan();
         end
         END_IN_WINDOW: begin
            write_stop_pts(33'($urandom_range(0, FRAME_TICKS_INT)));
            keep = $urandom_range(0, 5);
            for (int unsigned k = 0; k < keep; k++) plan_byte(8'($urandom));
            send_plan();
         end
         default: begin
            write_stop_pts(33'($urandom_range(0, FRAME_TICKS_INT)));
            if ($urandom_range(0, 1)) plan_video($urandom_range(0, 1));
            else plan_audio(random_pts(STAMP_MAX), 1'b0);
            keep = $urandom_range(WINDOW_HDR_LEN, plan.size() - 1);
            while (plan.size() > keep) void'(plan.pop_back());
            send_plan();
         end
      endcase
      if (!stream_done) offer_byte('{8'($urandom), 1'b1, 1'b0, 8'h00});

      // Once the stream has closed, further input must produce nothing.
      offer_byte('{8'($urandom), 1'b0, 1'b0, 8'h00});
      offer_byte('{8'($urandom), 1'b1, 1'b0, 8'h00});

      wait_for_idle();
      if (beats_due.size() != 0) begin
         errors++;
         $display("%0t: %0d beats still awaited, first expected %h/%b/%b/%b, actual none",
                  $time, beats_due.size(), beats_due[0].out_byte, beats_due[0].byte_valid,
                  beats_due[0].stream_closed, beats_due[0].last_of_run);
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
